// File: hw/rtl/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// wsfp_pkg
// types and constants shared by the websocket frame parser modules
// ----------------------------------------------------------------------------
package wsfp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        fin_bit;
        logic [3:0]  frame_opcode;
        logic        masked;
        logic [63:0] frame_length;
        logic [7:0]  payload_byte;
        logic        frame_end;
        logic        error_code;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_PAY  = 3'd4
    } phase_t;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic ERR_TOO_LONG  = 1'b0;
    localparam logic ERR_TRUNCATED = 1'b1;

    localparam logic [6:0]  LEN_EXT16     = 7'd126;
    localparam logic [6:0]  LEN_EXT64     = 7'd127;
    localparam logic [2:0]  EXT16_COUNT   = 3'd1;
    localparam logic [2:0]  EXT64_COUNT   = 3'd7;
    localparam logic [2:0]  KEY_COUNT     = 3'd3;
    localparam logic [31:0] MAX_LEN_RESET = 32'd10485760;

endpackage

// File: hw/rtl/wsfp_front.sv
// ----------------------------------------------------------------------------
// wsfp_front
// header parser and payload unmasker, one byte per cycle while step is high, one result at most
// ----------------------------------------------------------------------------
module wsfp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic                step,
    input  wsfp_pkg::in_item_t  in_item,
    output logic                res_valid,
    output wsfp_pkg::out_item_t res_item
);

    wsfp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] rem_reg, rem_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  kidx_reg, kidx_next;
    logic        fin_reg, fin_next;
    logic [3:0]  op_reg, op_next;
    logic        masked_reg, masked_next;
    logic [31:0] max_len_reg;

    logic [7:0]  b;
    logic        eob;
    logic [6:0]  l7;
    logic        l7_ext;
    logic [63:0] len_shift;
    logic [63:0] lk_len;
    logic        lk_over;
    logic        lk_masked;
    logic [63:0] hd_len;
    logic        hd_zero;
    logic [7:0]  key_byte;
    logic        pay_last;
    wsfp_pkg::phase_t lk_phase;
    wsfp_pkg::phase_t hd_phase;

    assign b         = in_item.data_byte;
    assign eob       = in_item.end_of_buffer;
    assign l7        = b[6:0];
    assign l7_ext    = (l7 == wsfp_pkg::LEN_EXT16) || (l7 == wsfp_pkg::LEN_EXT64);
    assign len_shift = {len_reg[55:0], b};
    assign pay_last  = (rem_reg == 64'd1);

    // length just completed, from the short field or the extended field
    always_comb begin
        if (phase_reg == wsfp_pkg::PH_HDR1) begin
            lk_len    = {57'd0, l7};
            lk_masked = b[7];
        end else begin
            lk_len    = len_shift;
            lk_masked = masked_reg;
        end
        lk_over = (|lk_len[63:32]) || (lk_len[31:0] > max_len_reg);
        hd_len  = (phase_reg == wsfp_pkg::PH_KEY) ? len_reg : lk_len;
        hd_zero = (hd_len == 64'd0);
    end

    always_comb begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        hd_phase = (hd_zero || eob) ? wsfp_pkg::PH_HDR0 : wsfp_pkg::PH_PAY;
        if (lk_over) begin
            lk_phase = wsfp_pkg::PH_HDR0;
        end else if (lk_masked) begin
            lk_phase = eob ? wsfp_pkg::PH_HDR0 : wsfp_pkg::PH_KEY;
        end else begin
            lk_phase = hd_phase;
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            unique case (phase_reg)
                wsfp_pkg::PH_HDR1: begin
                    if (l7_ext) begin
                        phase_next = eob ? wsfp_pkg::PH_HDR0 : wsfp_pkg::PH_EXT;
                    end else begin
                        phase_next = lk_phase;
                    end
                end
                wsfp_pkg::PH_EXT: begin
                    if (cnt_reg == 3'd0) begin
                        phase_next = lk_phase;
                    end else if (eob) begin
                        phase_next = wsfp_pkg::PH_HDR0;
                    end
                end
                wsfp_pkg::PH_KEY: begin
                    if (cnt_reg == 3'd0) begin
                        phase_next = hd_phase;
                    end else if (eob) begin
                        phase_next = wsfp_pkg::PH_HDR0;
                    end
                end
                wsfp_pkg::PH_PAY: begin
                    if (pay_last || eob) begin
                        phase_next = wsfp_pkg::PH_HDR0;
                    end
                end
                default: begin
                    phase_next = eob ? wsfp_pkg::PH_HDR0 : wsfp_pkg::PH_HDR1;
                end
            endcase
        end
    end

    // datapath and result
    always_comb begin
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        fin_next    = fin_reg;
        op_next     = op_reg;
        masked_next = masked_reg;
        res_valid   = 1'b0;
        res_item    = '0;
        if (step) begin
            unique case (phase_reg) inside
                wsfp_pkg::PH_HDR1, wsfp_pkg::PH_EXT: begin
                    if (phase_reg == wsfp_pkg::PH_HDR1) begin
                        masked_next = b[7];
                    end
                    len_next = (phase_reg == wsfp_pkg::PH_HDR1 && l7_ext) ? 64'd0 : lk_len;
                    if (phase_reg == wsfp_pkg::PH_HDR1 && l7_ext) begin
                        cnt_next = (l7 == wsfp_pkg::LEN_EXT16) ? wsfp_pkg::EXT16_COUNT
                                                               : wsfp_pkg::EXT64_COUNT;
                        if (eob) begin
                            res_valid           = 1'b1;
                            res_item.kind       = wsfp_pkg::KIND_ERROR;
                            res_item.error_code = wsfp_pkg::ERR_TRUNCATED;
                        end
                    end else if (phase_reg == wsfp_pkg::PH_EXT && cnt_reg != 3'd0) begin
                        cnt_next = cnt_reg - 3'd1;
                        if (eob) begin
                            res_valid           = 1'b1;
                            res_item.kind       = wsfp_pkg::KIND_ERROR;
                            res_item.error_code = wsfp_pkg::ERR_TRUNCATED;
                        end
                    end else if (lk_over) begin
                        res_valid           = 1'b1;
                        res_item.kind       = wsfp_pkg::KIND_ERROR;
                        res_item.error_code = wsfp_pkg::ERR_TOO_LONG;
                    end else if (lk_masked) begin
                        cnt_next = wsfp_pkg::KEY_COUNT;
                        key_next = 32'd0;
                        if (eob) begin
                            res_valid           = 1'b1;
                            res_item.kind       = wsfp_pkg::KIND_ERROR;
                            res_item.error_code = wsfp_pkg::ERR_TRUNCATED;
                        end
                    end else begin
                        res_valid = 1'b1;
                        if (hd_zero) begin
                            res_item.kind      = wsfp_pkg::KIND_HEADER;
                            res_item.frame_end = 1'b1;
                        end else if (eob) begin
                            res_item.kind       = wsfp_pkg::KIND_ERROR;
                            res_item.error_code = wsfp_pkg::ERR_TRUNCATED;
                        end else begin
                            res_item.kind         = wsfp_pkg::KIND_HEADER;
                            res_item.frame_length = hd_len;
                            rem_next              = hd_len;
                            kidx_next             = 2'd0;
                        end
                    end
                end
                wsfp_pkg::PH_KEY: begin
                    key_next = {key_reg[23:0], b};
                    if (cnt_reg != 3'd0) begin
                        cnt_next = cnt_reg - 3'd1;
                        if (eob) begin
                            res_valid           = 1'b1;
                            res_item.kind       = wsfp_pkg::KIND_ERROR;
                            res_item.error_code = wsfp_pkg::ERR_TRUNCATED;
                        end
                    end else begin
                        res_valid = 1'b1;
                        if (hd_zero) begin
                            res_item.kind      = wsfp_pkg::KIND_HEADER;
                            res_item.frame_end = 1'b1;
                        end else if (eob) begin
                            res_item.kind       = wsfp_pkg::KIND_ERROR;
                            res_item.error_code = wsfp_pkg::ERR_TRUNCATED;
                        end else begin
                            res_item.kind         = wsfp_pkg::KIND_HEADER;
                            res_item.frame_length = hd_len;
                            rem_next              = hd_len;
                            kidx_next             = 2'd0;
                        end
                    end
                end
                wsfp_pkg::PH_PAY: begin
                    kidx_next = kidx_reg + 2'd1;
                    rem_next  = rem_reg - 64'd1;
                    res_valid = 1'b1;
                    if (pay_last || !eob) begin
                        res_item.kind         = wsfp_pkg::KIND_PAYLOAD;
                        res_item.frame_length = len_reg;
                        res_item.payload_byte = masked_reg ? (b ^ key_byte) : b;
                        res_item.frame_end    = pay_last;
                    end else begin
                        res_item.kind       = wsfp_pkg::KIND_ERROR;
                        res_item.error_code = wsfp_pkg::ERR_TRUNCATED;
                    end
                end
                default: begin
                    fin_next    = b[7];
                    op_next     = b[3:0];
                    masked_next = 1'b0;
                    len_next    = 64'd0;
                    rem_next    = 64'd0;
                    key_next    = 32'd0;
                    kidx_next   = 2'd0;
                    cnt_next    = 3'd0;
                    if (eob) begin
                        res_valid           = 1'b1;
                        res_item.kind       = wsfp_pkg::KIND_ERROR;
                        res_item.error_code = wsfp_pkg::ERR_TRUNCATED;
                    end
                end
            endcase
        end
        res_item.fin_bit      = fin_next;
        res_item.frame_opcode = op_next;
        res_item.masked       = masked_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= wsfp_pkg::PH_HDR0;
            cnt_reg     <= 3'd0;
            len_reg     <= 64'd0;
            rem_reg     <= 64'd0;
            key_reg     <= 32'd0;
            kidx_reg    <= 2'd0;
            fin_reg     <= 1'b0;
            op_reg      <= 4'd0;
            masked_reg  <= 1'b0;
            max_len_reg <= wsfp_pkg::MAX_LEN_RESET;
        end else begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
            rem_reg    <= rem_next;
            key_reg    <= key_next;
            kidx_reg   <= kidx_next;
            fin_reg    <= fin_next;
            op_reg     <= op_next;
            masked_reg <= masked_next;
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// File: hw/rtl/wsfp_queue.sv
// ----------------------------------------------------------------------------
// wsfp_queue
// short result queue between parser and output stage
// ----------------------------------------------------------------------------
module wsfp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  wsfp_pkg::out_item_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output wsfp_pkg::out_item_t head_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    wsfp_pkg::out_item_t store [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_item = store[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/wsfp_back.sv
// ----------------------------------------------------------------------------
// wsfp_back
// output stage: drains the queue into the registered result channel
// ----------------------------------------------------------------------------
module wsfp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_not_empty,
    input  wsfp_pkg::out_item_t q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output wsfp_pkg::out_item_t m_item
);

    logic                m_valid_reg, m_valid_next;
    wsfp_pkg::out_item_t m_item_reg;

    assign q_pop        = q_not_empty && (!m_valid_reg || m_ready);
    assign m_valid_next = q_pop || (m_valid_reg && !m_ready);
    assign m_valid      = m_valid_reg;
    assign m_item       = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_item_reg <= q_head;
        end
    end

endmodule

// File: hw/rtl/websocket_frame_parser_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_parser_top
// websocket receive frame parser: header decode, length check, unmasking
// ----------------------------------------------------------------------------
//   channel  dir  handshake          item
//   s_       in   s_valid/s_ready    data_byte, end_of_buffer
//   m_       out  m_valid/m_ready    header, payload byte or error result
//   cfg_     in   cfg_wr_en          max frame length
//
// one byte taken per cycle while s_ready is high; each byte gives at most one result item
// a result reaches m_ by way of the result queue and then the output register
// s_ready drops only while the result queue is full, i.e. under m_ready stalls
// synchronous active-low reset; max frame length resets to 10485760
// ----------------------------------------------------------------------------
module websocket_frame_parser_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wsfp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output wsfp_pkg::out_item_t m_item,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data
);

    logic                step;
    logic                res_valid;
    wsfp_pkg::out_item_t res_item;
    logic                q_full;
    logic                q_pop;
    logic                q_not_empty;
    wsfp_pkg::out_item_t q_head;

    assign s_ready = !q_full;
    assign step    = s_valid && s_ready;

    wsfp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .in_item     (s_item),
        .res_valid   (res_valid),
        .res_item    (res_item)
    );

    wsfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_item (res_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head)
    );

    wsfp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

// File: hw/rtl/wsfp_checker.sv
// ----------------------------------------------------------------------------
// wsfp_checker
// port-level checks on the result channel of the frame parser
// ----------------------------------------------------------------------------
module wsfp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input wsfp_pkg::out_item_t m_item
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result item changed");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.kind == wsfp_pkg::KIND_HEADER ||
                     m_item.kind == wsfp_pkg::KIND_PAYLOAD ||
                     m_item.kind == wsfp_pkg::KIND_ERROR))
        else $error("bad result kind");

    a_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind == wsfp_pkg::KIND_ERROR |->
            !m_item.frame_end && m_item.frame_length == 64'd0 &&
            m_item.payload_byte == 8'd0)
        else $error("error item carries frame data");

    a_header_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind == wsfp_pkg::KIND_HEADER |->
            m_item.frame_end == (m_item.frame_length == 64'd0) &&
            m_item.payload_byte == 8'd0 && !m_item.error_code)
        else $error("header item end flag does not match length");

endmodule

bind websocket_frame_parser_top wsfp_checker u_wsfp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
